// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dsdiv_pkg.sv =====
`timescale 1ns / 1ps
package dsdiv_pkg;

   localparam int DIGIT_W = 4;
   localparam int REM_W   = 32;
   localparam int CFG_W   = 32;
   // A running remainder times ten plus a digit needs four more bits.
   localparam int CUR_W   = REM_W + 4;

   localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // start a new word: form remainder*10 + digit
      logic step;      // one restoring subtract, quotient digit plus one
      logic commit;    // division of this word is done, update state
      logic out_load;  // capture a result word into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_ok;   // another subtract is allowed
      logic emit;      // the finished word produces a result
   } status_type;

   function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
      return (d > MAX_DIGIT) ? MAX_DIGIT : d;
   endfunction

endpackage

// ===== hw/rtl/decimal_stream_divide_by_integer.sv =====
// Decimal long division of a digit stream by a programmable integer. Digits arrive
// most significant first on the req_ channel, one word per digit, with req_last_digit
// marking the end of a number. Each word forms remainder*10 + digit and finds the
// quotient digit by up to nine restoring compare-subtract steps on one shared
// subtractor. Each word is loaded, stepped through its subtracts and committed;
// a new result waits while rsp_stall holds an earlier one. req_stall is high while
// a word is in the divider. Leading quotient zeros produce no rsp_ word; a number
// smaller than the divisor yields a single 0. The last digit always produces a word
// with rsp_is_last set, the final remainder and a divisible flag, and clears the
// running state for the next number. Results sit in an output register, so a new
// digit is taken while an earlier result still waits behind rsp_stall. The divisor
// is written through the csr_ port while the block is idle; only its low
// DIVISOR_BITS bits are used, and zero acts as one. Digit values above nine are
// treated as nine.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_stream_divide_by_integer
   import dsdiv_pkg::*;
#(
   parameter int DIVISOR_BITS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   // Digit input channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [DIGIT_W-1:0] req_digit,
   input  logic               req_last_digit,
   // Quotient output channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIGIT_W-1:0] rsp_quotient_digit,
   output logic               rsp_is_last,
   output logic [REM_W-1:0]   rsp_remainder,
   output logic               rsp_divisible,
   // Divisor register write.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_divisor
);

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // The divisor register updates on a completed write handshake.
   assign csr_write = csr_valid && csr_ready;

   // The controller sequences load, subtract steps and commit for each word.
   dsdiv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the divisor, the running remainder and the output register.
   dsdiv_dp #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_divisor        (csr_divisor),
      .req_digit          (req_digit),
      .req_last_digit     (req_last_digit),
      .rsp_quotient_digit (rsp_quotient_digit),
      .rsp_is_last        (rsp_is_last),
      .rsp_remainder      (rsp_remainder),
      .rsp_divisible      (rsp_divisible)
   );

   // A shown quotient digit never exceeds nine.
   `ASSERT_IMPLY(a_digit_range, clock, reset, rsp_valid, rsp_quotient_digit <= MAX_DIGIT, "quotient digit above nine")
   // Remainder and divisible flag are zero on every word but the last one.
   `ASSERT_IMPLY(a_mid_fields, clock, reset, rsp_valid && !rsp_is_last, rsp_remainder == '0 && !rsp_divisible, "remainder fields set before last word")
   // The divisible flag agrees with the remainder it travels with.
   `ASSERT_IMPLY(a_divisible, clock, reset, rsp_valid && rsp_divisible, rsp_remainder == '0, "divisible flag with nonzero remainder")
   // An accepted digit keeps the input stalled for at least the next cycle.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall && !csr_ready, "input not stalled while dividing")

endmodule

// ===== hw/rtl/dsdiv_ctrl.sv =====
`timescale 1ns / 1ps
module dsdiv_ctrl
   import dsdiv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       csr_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_busy;

   assign out_busy  = out_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.step_ok) begin
               cmd.step = 1'b1;
            end else if (!(status.emit && out_busy)) begin
               // Hold the finished word until the output register frees up.
               cmd.commit   = 1'b1;
               cmd.out_load = status.emit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hw/rtl/dsdiv_dp.sv =====
`timescale 1ns / 1ps
module dsdiv_dp
   import dsdiv_pkg::*;
#(
   parameter int DIVISOR_BITS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write,
   input  logic [CFG_W-1:0]   csr_divisor,
   input  logic [DIGIT_W-1:0] req_digit,
   input  logic               req_last_digit,
   output logic [DIGIT_W-1:0] rsp_quotient_digit,
   output logic               rsp_is_last,
   output logic [REM_W-1:0]   rsp_remainder,
   output logic               rsp_divisible
);

   localparam int DIV_W = (DIVISOR_BITS < CFG_W) ? DIVISOR_BITS : CFG_W;

   logic [DIV_W-1:0]   div_ff, div_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               started_ff, started_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [DIGIT_W-1:0] q_ff, q_in;
   logic               last_ff, last_in;
   logic [DIGIT_W-1:0] oq_ff, oq_in;
   logic               olast_ff, olast_in;
   logic [REM_W-1:0]   orem_ff, orem_in;
   logic               odiv_ff, odiv_in;

   logic [CUR_W-1:0]   div_ext;
   logic [CUR_W-1:0]   rem_ext;
   logic [REM_W-1:0]   cur_low;

   assign div_ext = CUR_W'(div_ff);
   assign rem_ext = CUR_W'(rem_ff);
   assign cur_low = cur_ff[REM_W-1:0];

   assign status.step_ok = (q_ff != MAX_DIGIT) && (cur_ff >= div_ext);
   assign status.emit    = started_ff || (q_ff != '0) || last_ff;

   always_comb begin
      div_in = div_ff;
      if (csr_write) begin
         // Only the low bits count, and a zero divisor acts as one.
         div_in = (csr_divisor[DIV_W-1:0] == '0) ? DIV_W'(1) : csr_divisor[DIV_W-1:0];
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      q_in    = q_ff;
      last_in = last_ff;
      if (cmd.load) begin
         cur_in  = (rem_ext << 3) + (rem_ext << 1) + CUR_W'(sat_digit(req_digit));
         q_in    = '0;
         last_in = req_last_digit;
      end else if (cmd.step) begin
         cur_in = cur_ff - div_ext;
         q_in   = q_ff + DIGIT_W'(1);
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      started_in = started_ff;
      if (cmd.commit) begin
         rem_in     = last_ff ? '0 : cur_low;
         started_in = last_ff ? 1'b0 : (started_ff || status.emit);
      end
   end

   always_comb begin
      oq_in    = oq_ff;
      olast_in = olast_ff;
      orem_in  = orem_ff;
      odiv_in  = odiv_ff;
      if (cmd.out_load) begin
         oq_in    = q_ff;
         olast_in = last_ff;
         orem_in  = last_ff ? cur_low : '0;
         odiv_in  = last_ff && (cur_low == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff     <= DIV_W'(1);
         rem_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         div_ff     <= div_in;
         rem_ff     <= rem_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      q_ff     <= q_in;
      last_ff  <= last_in;
      oq_ff    <= oq_in;
      olast_ff <= olast_in;
      orem_ff  <= orem_in;
      odiv_ff  <= odiv_in;
   end

   assign rsp_quotient_digit = oq_ff;
   assign rsp_is_last        = olast_ff;
   assign rsp_remainder      = orem_ff;
   assign rsp_divisible      = odiv_ff;

endmodule

// ===== bench/tb_decimal_stream_divide_by_integer.sv =====
`timescale 1ns / 1ps
module tb_decimal_stream_divide_by_integer;
   import dsdiv_pkg::*;

   // Ten times the running remainder plus a digit.
   localparam int RADIX = 10;
   // Leave a margin for the longest word in the divider before touching the
   // divisor and before the final verdict.
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES = 24;
   // This is how long the receiver holds off to back the divider up.
   localparam int HOLD_CYCLES = 300;
   // The watchdog trips after this many cycles with no handshake on any port.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PHASES = 10;
   localparam int WORDS_PER_PHASE = 70;

   // One quotient word as it leaves the rsp_ channel.
   typedef struct packed {
      logic [DIGIT_W-1:0] quotient_digit;
      logic               is_last;
      logic [REM_W-1:0]   remainder;
      logic               divisible;
   } quot_word_type;

   // A directed row either sends a digit word or rewrites the divisor.
   typedef enum logic [0:0] {ROW_DIGIT, ROW_DIVISOR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [31:0]   value;
      logic          last;
      logic          typed;
      quot_word_type want;
   } stim_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [DIGIT_W-1:0] req_digit = '0;
   logic               req_last_digit = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DIGIT_W-1:0] rsp_quotient_digit;
   logic               rsp_is_last;
   logic [REM_W-1:0]   rsp_remainder;
   logic               rsp_divisible;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_divisor = '0;

   // This is the bench's own copy of the divider state, advanced on every accepted digit.
   logic [CFG_W-1:0]   divisor_now = 1;
   logic [REM_W-1:0]   running_rem = '0;
   bit                 number_started = 1'b0;

   // Quotient words predicted but not yet seen on the rsp_ channel, oldest first.
   quot_word_type      pending_quotients[$];
   stim_row_type       directed_rows[$];

   int                 mismatches = 0;
   int                 quiet_cycles = 0;
   bit                 req_idle_on = 1'b1;
   bit                 rsp_idle_on = 1'b1;
   bit                 hold_off_req = 1'b0;

   decimal_stream_divide_by_integer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_digit          (req_digit),
      .req_last_digit     (req_last_digit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient_digit (rsp_quotient_digit),
      .rsp_is_last        (rsp_is_last),
      .rsp_remainder      (rsp_remainder),
      .rsp_divisible      (rsp_divisible),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_divisor        (csr_divisor)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // This is one step of long division. It forms remainder*10 + digit, takes
   // the quotient digit and keeps what is left. The function returns 1 when
   // the step produces a word. A zero divisor acts as one, and digits above
   // nine count as nine. If the divisor shrank in the middle of a number, the
   // quotient digit is capped at nine and the leftover is cut to 32 bits.
   function automatic bit divide_digit(input logic [DIGIT_W-1:0] digit,
                                       input logic last, output quot_word_type word);
      logic [63:0] dvs;
      logic [63:0] partial;
      logic [63:0] quo;
      logic [63:0] leftover;
      logic [DIGIT_W-1:0] clipped;
      dvs = (divisor_now == 0) ? 64'd1 : {32'd0, divisor_now};
      clipped = (digit > MAX_DIGIT) ? MAX_DIGIT : digit;
      partial = {32'd0, running_rem} * 64'(RADIX) + {60'd0, clipped};
      quo = partial / dvs;
      if (quo > MAX_DIGIT) begin
         quo = 64'(MAX_DIGIT);
      end
      leftover = partial - quo * dvs;
      word.quotient_digit = quo[DIGIT_W-1:0];
      word.is_last = last;
      word.remainder = last ? leftover[REM_W-1:0] : '0;
      word.divisible = last && (leftover[REM_W-1:0] == 0);
      if (last) begin
         running_rem = '0;
         number_started = 1'b0;
         return 1'b1;
      end
      running_rem = leftover[REM_W-1:0];
      // Leading zeros of the quotient stay silent.
      if (!number_started && quo == 0) begin
         return 1'b0;
      end
      number_started = 1'b1;
      return 1'b1;
   endfunction

   // The typed expectation (q, rem) is only meaningful when typed is set.
   task automatic add_row(input row_kind_type kind, input logic [31:0] value,
                          input logic last, input bit typed,
                          input logic [DIGIT_W-1:0] q, input logic [REM_W-1:0] rem);
      stim_row_type row;
      row.kind = kind;
      row.value = value;
      row.last = last;
      row.typed = typed;
      row.want.quotient_digit = q;
      row.want.is_last = last;
      row.want.remainder = last ? rem : '0;
      row.want.divisible = last && (rem == 0);
      directed_rows.push_back(row);
   endtask

   // The task offers one digit word and holds it until it is taken. It then
   // records what the divider should answer. The valid line stays high on
   // return, and the caller decides whether a gap follows.
   task automatic send_word(input logic [DIGIT_W-1:0] digit, input logic last,
                            input bit typed, input quot_word_type typed_word);
      quot_word_type word;
      bit gives;
      req_valid <= 1'b1;
      req_digit <= digit;
      req_last_digit <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      gives = divide_digit(digit, last, word);
      if (typed) begin
         pending_quotients.push_back(typed_word);
      end else if (gives) begin
         pending_quotients.push_back(word);
      end
   endtask

   // On roughly 14 words in a hundred the sender drops valid and leaves a gap.
   task automatic sender_gap();
      if (req_idle_on && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // The divisor may only change while the divider is empty. All predicted
   // words must have arrived first. A digit that gives no word can still be
   // in flight after that, so the task also lets the divider settle.
   task automatic write_divisor(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_quotients.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_divisor <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      divisor_now = value;
   endtask

   // This process owns rsp_stall. It stalls at random and, on request, holds
   // off for a long stretch so that the divider fills and stalls its input.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= rsp_idle_on && ($urandom_range(0, 99) < 14);
         end
      end
   end

   // Every accepted quotient word is compared with the oldest prediction.
   always @(posedge clock) begin : check_quotients
      quot_word_type got;
      quot_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_quotient_digit, rsp_is_last, rsp_remainder, rsp_divisible};
         if (pending_quotients.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("tb: unexpected word q=%0d last=%0b rem=%0d div=%0b",
                        got.quotient_digit, got.is_last, got.remainder, got.divisible);
            end
            mismatches++;
         end else begin
            want = pending_quotients.pop_front();
            if (got !== want) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("tb: mismatch expected q=%0d last=%0b rem=%0d div=%0b",
                           want.quotient_digit, want.is_last, want.remainder,
                           want.divisible);
                  $display("tb:          actual   q=%0d last=%0b rem=%0d div=%0b",
                           got.quotient_digit, got.is_last, got.remainder,
                           got.divisible);
               end
               mismatches++;
            end
         end
      end
   end

   // The watchdog counts cycles with no handshake on any of the three ports.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      quot_word_type none;
      int phase;
      int count;
      int digits_left;
      logic [CFG_W-1:0] pick;
      logic [DIGIT_W-1:0] digit;

      none = '0;
      digits_left = 0;

      // The directed part starts at the reset divisor of one. Each digit then
      // comes back as itself, and a digit above nine comes back as nine.
      add_row(ROW_DIGIT, 7, 1'b1, 1'b1, 7, 0);
      add_row(ROW_DIGIT, 15, 1'b1, 1'b1, 9, 0);
      add_row(ROW_DIGIT, 0, 1'b1, 1'b1, 0, 0);
      // A zero divisor behaves as one.
      add_row(ROW_DIVISOR, 0, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 8, 1'b0, 1'b1, 8, 0);
      add_row(ROW_DIGIT, 10, 1'b1, 1'b1, 9, 0);
      // This is 1234 / 7. The leading quotient zero is suppressed.
      add_row(ROW_DIVISOR, 7, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 1, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 2, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 3, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 4, 1'b1, 1'b0, 0, 0);
      // This number, 05, is below the divisor and gives a lone zero with remainder 5.
      add_row(ROW_DIGIT, 0, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 5, 1'b1, 1'b1, 0, 5);
      // The largest divisor divides itself exactly, and nine leading zeros stay silent.
      add_row(ROW_DIVISOR, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 4, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 2, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 4, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 6, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 7, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 2, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 5, 1'b1, 1'b1, 1, 0);
      // The divisor shrinks in the middle of a number. The running remainder
      // of 999 is no longer below it, so the next quotient digit saturates.
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 9, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIVISOR, 100, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 5, 1'b0, 1'b0, 0, 0);
      add_row(ROW_DIGIT, 0, 1'b1, 1'b0, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_DIVISOR) begin
            write_divisor(row.value);
         end else begin
            send_word(row.value[DIGIT_W-1:0], row.last, row.typed, row.want);
            sender_gap();
         end
      end

      // In the random part each phase starts with a new divisor, written
      // while the divider is empty. Numbers run across phase boundaries, so
      // many divisor changes land in the middle of a number.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: pick = 32'hFFFF_FFFF;
            1: pick = '0;
            2: pick = 1;
            default: begin
               if ($urandom_range(0, 9) < 6) begin
                  pick = $urandom_range(2, 30);
               end else if ($urandom_range(0, 1) == 0) begin
                  pick = $urandom_range(31, 100000);
               end else begin
                  pick = $urandom;
               end
            end
         endcase
         write_divisor(pick);

         // In phase three neither side idles. In phase five the receiver
         // backs up the divider while the sender keeps offering digits.
         req_idle_on = (phase != 3);
         rsp_idle_on = (phase != 3);
         if (phase == 5) begin
            hold_off_req = 1'b1;
         end

         for (count = 0; count < WORDS_PER_PHASE; count++) begin
            if (digits_left == 0) begin
               digits_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20)
                                                         : $urandom_range(1, 12);
            end
            // Most digits are well formed. A few lie above nine.
            if ($urandom_range(0, 99) < 6) begin
               digit = DIGIT_W'($urandom_range(10, 15));
            end else begin
               digit = DIGIT_W'($urandom_range(0, 9));
            end
            send_word(digit, digits_left == 1, 1'b0, none);
            digits_left--;
            sender_gap();
         end
      end

      req_valid <= 1'b0;
      while (pending_quotients.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dsdiv_pkg.sv
hw/rtl/dsdiv_ctrl.sv
hw/rtl/dsdiv_dp.sv
hw/rtl/decimal_stream_divide_by_integer.sv
bench/tb_decimal_stream_divide_by_integer.sv
